// ===== sv/sqm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sqm_pkg;

   localparam int MAX_BITS = 12;
   localparam int SYM_W    = 12;
   localparam int BPS_W    = 4;
   localparam int SCALE_W  = 16;
   localparam int OUT_W    = 23;
   localparam int HALF_W   = MAX_BITS / 2;
   localparam int SHIFT_W  = BPS_W - 1;
   localparam int LVL_W    = HALF_W + 1;
   localparam int AMP_W    = HALF_W + 2;
   localparam int PROD_W   = AMP_W + SCALE_W + 1;
   localparam int CSR_W    = 16;
   localparam int IDX_W    = 1;

   localparam logic [IDX_W-1:0]   REG_BPS   = 1'b0;
   localparam logic [IDX_W-1:0]   REG_SCALE = 1'b1;

   localparam logic [BPS_W-1:0]   BPS_RESET   = 4'd2;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd46341;

   typedef struct packed {
      logic signed [AMP_W-1:0] i_amp;
      logic signed [AMP_W-1:0] q_amp;
   } amp_pair_type;

   // Each bit becomes the xor of itself and every bit above it. Bits above
   // the live width are zero, so they do not disturb the prefix.
   function automatic logic [HALF_W-1:0] gray_decode(input logic [HALF_W-1:0] g);
      logic [HALF_W-1:0] r;
      logic              acc;
      acc = 1'b0;
      r   = '0;
      for (int k = HALF_W - 1; k >= 0; k--) begin
         acc  = acc ^ g[k];
         r[k] = acc;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sqm_level_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqm_level_map (
   input  wire logic [sqm_pkg::SYM_W-1:0] symbol,
   input  wire logic [sqm_pkg::BPS_W-1:0] bits_per_symbol,
   output sqm_pkg::amp_pair_type          amp
);

   logic [sqm_pkg::SHIFT_W-1:0] half;
   logic [sqm_pkg::SYM_W-1:0]   sym_mask;
   logic [sqm_pkg::SYM_W-1:0]   b;
   logic [sqm_pkg::SYM_W-1:0]   g;
   logic [sqm_pkg::HALF_W-1:0]  half_mask;
   logic [sqm_pkg::HALF_W-1:0]  g_hi;
   logic [sqm_pkg::HALF_W-1:0]  g_lo;
   logic [sqm_pkg::HALF_W-1:0]  idx_i;
   logic [sqm_pkg::HALF_W-1:0]  idx_q;
   logic [sqm_pkg::LVL_W-1:0]   levels;

   assign half      = bits_per_symbol[sqm_pkg::BPS_W-1:1];
   assign sym_mask  = ~({sqm_pkg::SYM_W{1'b1}} << bits_per_symbol);
   assign b         = symbol & sym_mask;
   assign g         = b ^ (b >> 1);
   assign half_mask = ~({sqm_pkg::HALF_W{1'b1}} << half);
   assign g_hi      = sqm_pkg::HALF_W'(g >> half) & half_mask;
   assign g_lo      = sqm_pkg::HALF_W'(g) & half_mask;
   assign idx_i     = sqm_pkg::gray_decode(g_hi);
   assign idx_q     = sqm_pkg::gray_decode(g_lo);
   assign levels    = sqm_pkg::LVL_W'(1) << half;

   // Amplitude 2*idx - L + 1, kept in AMP_W bits; the value always fits.
   assign amp.i_amp = $signed({1'b0, idx_i, 1'b0}) - $signed({1'b0, levels})
                      + $signed(sqm_pkg::AMP_W'(1));
   assign amp.q_amp = $signed({1'b0, idx_q, 1'b0}) - $signed({1'b0, levels})
                      + $signed(sqm_pkg::AMP_W'(1));

endmodule

`default_nettype wire

// ===== sv/square_qam_symbol_mapper.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_symbol_bits[11:0]
// rsp       out        rsp_valid/rsp_ready   rsp_in_phase[22:0], rsp_quadrature[22:0]
// csr       in         csr_we (no wait)      csr_index[0:0], csr_wdata[15:0]
//
// One request per cycle is accepted while rsp is not stalled; each result passes
// from its request through the input register and then the result register.
// The stage between them holds the Gray mapping and two 8 x 17 bit multiplies.
// Reset is synchronous and empties both stages and restores the registers.
// A stall on rsp holds the result register; req_ready drops only when both
// stages are full and rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module square_qam_symbol_mapper (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sqm_pkg::SYM_W-1:0]         req_symbol_bits,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [sqm_pkg::OUT_W-1:0]       rsp_in_phase,
   output logic signed [sqm_pkg::OUT_W-1:0]       rsp_quadrature,
   input  wire logic                              csr_we,
   input  wire logic [sqm_pkg::IDX_W-1:0]         csr_index,
   input  wire logic [sqm_pkg::CSR_W-1:0]         csr_wdata
);

   logic [sqm_pkg::BPS_W-1:0]        bps_ff, bps_in;
   logic [sqm_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic                             s1_vld_ff, s1_vld_in;
   logic [sqm_pkg::SYM_W-1:0]        sym_ff;
   logic                             out_vld_ff, out_vld_in;
   logic signed [sqm_pkg::OUT_W-1:0] i_ff, q_ff;

   logic                             req_take;
   logic                             s1_adv;
   logic [sqm_pkg::BPS_W-1:0]        bps_wr;
   sqm_pkg::amp_pair_type            amp;
   logic signed [sqm_pkg::PROD_W-1:0] i_prod, q_prod;

   assign s1_adv    = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   // Only even widths from two up to the maximum are taken.
   assign bps_wr = csr_wdata[sqm_pkg::BPS_W-1:0];

   always_comb begin
      bps_in   = bps_ff;
      scale_in = scale_ff;
      if (csr_we) begin
         unique case (csr_index)
            sqm_pkg::REG_BPS: begin
               if (!bps_wr[0] && bps_wr >= sqm_pkg::BPS_W'(2)
                   && bps_wr <= sqm_pkg::BPS_W'(sqm_pkg::MAX_BITS)) begin
                  bps_in = bps_wr;
               end
            end
            sqm_pkg::REG_SCALE: begin
               scale_in = csr_wdata[sqm_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_take) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (s1_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   sqm_level_map u_level_map (
      .symbol          (sym_ff),
      .bits_per_symbol (bps_ff),
      .amp             (amp)
   );

   assign i_prod = amp.i_amp * $signed({1'b0, scale_ff});
   assign q_prod = amp.q_amp * $signed({1'b0, scale_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff     <= sqm_pkg::BPS_RESET;
         scale_ff   <= sqm_pkg::SCALE_RESET;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         bps_ff     <= bps_in;
         scale_ff   <= scale_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sym_ff <= req_symbol_bits;
      end
      if (s1_adv) begin
         i_ff <= i_prod[sqm_pkg::OUT_W-1:0];
         q_ff <= q_prod[sqm_pkg::OUT_W-1:0];
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_in_phase   = i_ff;
   assign rsp_quadrature = q_ff;

endmodule

`default_nettype wire

// ===== sv/sqm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqm_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [sqm_pkg::OUT_W-1:0]   rsp_in_phase,
   input wire logic signed [sqm_pkg::OUT_W-1:0]   rsp_quadrature
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_in_phase)
                                   && $stable(rsp_quadrature))
      else $error("result changed while stalled");

   // A result only leaves when it was taken.
   a_rsp_leave: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result dropped without being taken");

   // With the output side open the block never refuses a request.
   a_no_stall: assert property (@(posedge clock)
      !reset && rsp_ready |-> req_ready)
      else $error("request refused while output is open");

   // An accepted request shows up as a result through the input and result registers when unblocked.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted request did not produce a result");

endmodule

bind square_qam_symbol_mapper sqm_checker u_sqm_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 55;

   typedef struct packed {
      logic signed [sqm_pkg::OUT_W-1:0] in_phase;
      logic signed [sqm_pkg::OUT_W-1:0] quadrature;
   } constellation_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [sqm_pkg::SYM_W-1:0] req_symbol_bits = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [sqm_pkg::OUT_W-1:0] rsp_in_phase;
   logic signed [sqm_pkg::OUT_W-1:0] rsp_quadrature;
   logic csr_we = 1'b0;
   logic [sqm_pkg::IDX_W-1:0] csr_index = '0;
   logic [sqm_pkg::CSR_W-1:0] csr_wdata = '0;

   // Register copies that the predictor works from.
   logic [sqm_pkg::BPS_W-1:0] model_bps = sqm_pkg::BPS_RESET;
   logic [sqm_pkg::SCALE_W-1:0] model_scale = sqm_pkg::SCALE_RESET;

   logic [sqm_pkg::SYM_W-1:0] symbol_feed[$];
   constellation_point_type expected_points[$];
   int n_symbols_queued = 0;
   int n_req_sent = 0;
   int n_req_taken = 0;
   int n_errors = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit idle_on = 1'b0;

   square_qam_symbol_mapper u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol_bits (req_symbol_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_in_phase    (rsp_in_phase),
      .rsp_quadrature  (rsp_quadrature),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Prefix xor from the top bit down turns a Gray code into a level index.
   function automatic int gray_to_level(input int g, input int width);
      int acc;
      int r;
      acc = 0;
      r = 0;
      for (int k = width - 1; k >= 0; k--) begin
         acc = acc ^ ((g >> k) & 1);
         r = r | (acc << k);
      end
      return r;
   endfunction

   function automatic logic signed [sqm_pkg::OUT_W-1:0] level_value(
         input int idx, input int half, input logic [sqm_pkg::SCALE_W-1:0] s);
      longint prod;
      prod = longint'(2 * idx - (1 << half) + 1) * longint'(s);
      return prod[sqm_pkg::OUT_W-1:0];
   endfunction

   function automatic constellation_point_type map_symbol(
         input logic [sqm_pkg::SYM_W-1:0] word,
         input logic [sqm_pkg::BPS_W-1:0] m,
         input logic [sqm_pkg::SCALE_W-1:0] amp_scale);
      constellation_point_type pt;
      int half;
      int half_mask;
      int b;
      int g;
      half = int'(m) / 2;
      half_mask = (1 << half) - 1;
      b = int'(word) & ((1 << int'(m)) - 1);
      g = b ^ (b >> 1);
      pt.in_phase = level_value(gray_to_level((g >> half) & half_mask, half), half, amp_scale);
      pt.quadrature = level_value(gray_to_level(g & half_mask, half), half, amp_scale);
      return pt;
   endfunction

   // Mostly back to back, some short gaps, a few long ones; none at all when not busy.
   function automatic int pick_gap(input bit busy);
      int roll;
      roll = $urandom_range(0, 99);
      if (!busy || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request driver. The slot is free once the request on the bus has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || n_req_taken == n_req_sent) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (symbol_feed.size() != 0) begin
            req_valid <= 1'b1;
            req_symbol_bits <= symbol_feed.pop_front();
            n_req_sent <= n_req_sent + 1;
            req_gap <= pick_gap(idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall <= pick_gap(idle_on);
      end
   end

   always @(posedge clock) begin
      constellation_point_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_points.push_back(map_symbol(req_symbol_bits, model_bps, model_scale));
            n_req_taken <= n_req_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("result with no request waiting: in_phase %0d quadrature %0d",
                      rsp_in_phase, rsp_quadrature);
               n_errors++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_in_phase !== want.in_phase) begin
                  $error("in_phase: expected %0d, got %0d", want.in_phase, rsp_in_phase);
                  n_errors++;
               end
               if (rsp_quadrature !== want.quadrature) begin
                  $error("quadrature: expected %0d, got %0d", want.quadrature,
                         rsp_quadrature);
                  n_errors++;
               end
            end
         end
      end
   end

   task automatic write_csr(input logic [sqm_pkg::IDX_W-1:0] idx,
                            input logic [sqm_pkg::CSR_W-1:0] data);
      logic [sqm_pkg::BPS_W-1:0] bps;
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      bps = data[sqm_pkg::BPS_W-1:0];
      if (idx == sqm_pkg::REG_BPS) begin
         // Odd widths and widths outside 2..MAX_BITS leave the register alone.
         if (!bps[0] && bps >= 2 && bps <= sqm_pkg::MAX_BITS) model_bps = bps;
      end else if (idx == sqm_pkg::REG_SCALE) begin
         model_scale = data;
      end
   endtask

   task automatic send_symbol(input logic [sqm_pkg::SYM_W-1:0] word);
      symbol_feed.push_back(word);
      n_symbols_queued++;
   endtask

   // Wait until every request is taken and every result checked, then let the
   // pipeline settle before the registers are touched.
   task automatic drain();
      while (!(n_req_taken == n_symbols_queued && expected_points.size() == 0))
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [sqm_pkg::CSR_W-1:0] bps_data[8];
      logic [sqm_pkg::CSR_W-1:0] scale_data[8];
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // Reset values, two bits per symbol; upper input bits must be ignored.
      send_symbol(12'h000);
      send_symbol(12'h001);
      send_symbol(12'h002);
      send_symbol(12'h003);
      send_symbol(12'hFFC);
      send_symbol(12'hFFF);
      drain();

      // Odd, too small and too large widths are all dropped.
      write_csr(sqm_pkg::REG_BPS, 16'd5);
      write_csr(sqm_pkg::REG_BPS, 16'd0);
      write_csr(sqm_pkg::REG_BPS, 16'd14);
      write_csr(sqm_pkg::REG_BPS, 16'd15);
      write_csr(sqm_pkg::REG_SCALE, 16'hFFFF);
      for (int k = 0; k < 4; k++) send_symbol(sqm_pkg::SYM_W'(k));
      drain();

      // Bits above the register width are masked, giving twelve bits per symbol.
      write_csr(sqm_pkg::REG_BPS, 16'hFFFC);
      send_symbol(12'h000);
      send_symbol(12'hFFF);
      send_symbol(12'h800);
      send_symbol(12'h7FF);
      send_symbol(12'hAAA);
      send_symbol(12'h555);
      send_symbol(12'h0C3);
      send_symbol(12'hF3C);
      drain();

      write_csr(sqm_pkg::REG_SCALE, 16'd0);
      send_symbol(12'hFFF);
      send_symbol(12'h123);
      drain();

      bps_data = '{16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd2, 16'($urandom), 16'd12};
      scale_data = '{16'($urandom), sqm_pkg::SCALE_RESET, 16'hFFFF, 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'd1};
      for (int p = 0; p < 8; p++) begin
         write_csr(sqm_pkg::REG_BPS, bps_data[p]);
         write_csr(sqm_pkg::REG_SCALE, scale_data[p]);
         idle_on = (p % 3 != 0);
         for (int k = 0; k < RANDOM_PER_PHASE; k++)
            send_symbol(sqm_pkg::SYM_W'($urandom_range(0, (1 << sqm_pkg::SYM_W) - 1)));
         drain();
      end

      repeat (8) @(negedge clock);
      if (n_errors == 0 && expected_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      for (int cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
